@@ rtl/slmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmm_pkg: shared types and constants of the sparse-left matrix multiplier
// Store geometry, request and register codes, the configuration struct and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package slmm_pkg;

  // Store geometry: 64 x 64 entries addressed by {row, column}
  localparam int SIDE      = 64;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DIM_W     = 7;
  localparam int VAL_W     = 38;
  localparam int CFG_IDX_W = 3;

  // Request codes
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_M  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_K  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_N  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_B = 3'd4;

  // Effective configuration, dimensions already clamped
  typedef struct packed {
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_k;
    logic [DIM_W-1:0] dim_n;
    logic             flip_a;
    logic             flip_b;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic              a_re;
    logic [ADDR_W-1:0] a_raddr;
    logic              a_latch;
    logic              mac_issue;
    logic              mac_first;
    logic [ADDR_W-1:0] b_raddr;
    logic              acc_re;
    logic [IDX_W-1:0]  col;
    logic              out_load;
    logic              out_load_err;
    logic              out_zero;
    logic              out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic a_zero;
  } dp_stat_t;

  // Clamp a dimension into 1..lim
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (r == '0) r = 7'd1;
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/slmm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmm_datapath: stores, multiply-accumulate pipeline and result register
// A and B stores with registered reads, one shared multiplier, a per-column
// accumulator memory updated by a three-stage read-modify-write pipeline.
// ----------------------------------------------------------------------------
module slmm_datapath import slmm_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dp_cmd_t                     cmd_i,
  output      dp_stat_t                    stat_o,
  input  wire logic [IDX_W-1:0]            row_index_i,
  input  wire logic [IDX_W-1:0]            col_index_i,
  input  wire logic signed [DATA_BITS-1:0] element_value_i,
  output      logic [IDX_W-1:0]            out_col_o,
  output      logic signed [VAL_W-1:0]     out_value_o,
  output      logic                        last_o,
  output      logic                        error_o
);

  logic [DATA_BITS-1:0] a_mem [SIDE*SIDE];
  logic [DATA_BITS-1:0] b_mem [SIDE*SIDE];
  logic [VAL_W-1:0]     acc_mem [SIDE];

  logic [DATA_BITS-1:0]          a_rdata_q, b_rdata_q, a_q;
  logic [VAL_W-1:0]              acc_rdata_q;
  logic [ADDR_W-1:0]             wr_addr;

  logic                          s1_valid_q, s1_first_q;
  logic [IDX_W-1:0]              s1_col_q;
  logic                          s2_valid_q, s2_first_q;
  logic [IDX_W-1:0]              s2_col_q;
  logic signed [VAL_W-1:0]       prod_q, s2_acc_q, sum;
  logic signed [2*DATA_BITS-1:0] prod_full;

  logic [IDX_W-1:0]              out_col_q;
  logic signed [VAL_W-1:0]       out_value_q;
  logic                          last_q, error_q;

  assign wr_addr = {row_index_i, col_index_i};

  // A store: load writes, registered read for the current inner index
  always_ff @(posedge clk_i) begin
    if (cmd_i.a_we) a_mem[wr_addr] <= element_value_i;
    if (cmd_i.a_re) a_rdata_q <= a_mem[cmd_i.a_raddr];
  end

  // B store: load writes, registered read per issued term
  always_ff @(posedge clk_i) begin
    if (cmd_i.b_we) b_mem[wr_addr] <= element_value_i;
    if (cmd_i.mac_issue) b_rdata_q <= b_mem[cmd_i.b_raddr];
  end

  // Held A operand for the running pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.a_latch) a_q <= a_rdata_q;
  end

  assign stat_o.a_zero = (a_rdata_q == '0);

  // Accumulator memory: read at issue, written back from the second pipeline stage
  assign sum = s2_first_q ? prod_q : s2_acc_q + prod_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) acc_mem[s2_col_q] <= sum;
    if (cmd_i.acc_re) acc_rdata_q <= acc_mem[cmd_i.col];
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.mac_issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Multiply stage, product sign-extended to the result width
  assign prod_full = $signed(a_q) * $signed(b_rdata_q);

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.mac_first;
    s1_col_q   <= cmd_i.col;
    s2_first_q <= s1_first_q;
    s2_col_q   <= s1_col_q;
    prod_q     <= VAL_W'(prod_full);
    s2_acc_q   <= acc_rdata_q;
  end

  // Result register; a bad row gives column 0, value 0, last and error set
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_err) begin
      out_col_q   <= '0;
      out_value_q <= '0;
      last_q      <= 1'b1;
      error_q     <= 1'b1;
    end else if (cmd_i.out_load) begin
      out_col_q   <= cmd_i.col;
      out_value_q <= cmd_i.out_zero ? '0 : acc_rdata_q;
      last_q      <= cmd_i.out_last;
      error_q     <= 1'b0;
    end
  end

  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

endmodule
`default_nettype wire

@@ rtl/slmm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmm_ctrl: request sequencer
// Takes requests, checks load bounds and compute rows, walks the inner index
// and the output columns of a compute, skips zero A terms and hands results out.
// ----------------------------------------------------------------------------
module slmm_ctrl import slmm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [IDX_W-1:0] row_index_i,
  input  wire logic [IDX_W-1:0] col_index_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      dp_cmd_t          cmd_o,
  input  wire dp_stat_t         stat_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_WAIT,
    ST_B_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_SEND,
    ST_ERR_SEND
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] row_q, t_q, j_q;
  logic             any_pass_q, pass_first_q, out_valid_q;

  logic             in_accept, t_last, j_last, row_bad;
  logic [DIM_W-1:0] row7, col7, a_rows, a_cols, b_rows, b_cols;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Bounds of the stored matrices
  assign row7   = {1'b0, row_index_i};
  assign col7   = {1'b0, col_index_i};
  assign a_rows = cfg_i.flip_a ? cfg_i.dim_k : cfg_i.dim_m;
  assign a_cols = cfg_i.flip_a ? cfg_i.dim_m : cfg_i.dim_k;
  assign b_rows = cfg_i.flip_b ? cfg_i.dim_n : cfg_i.dim_k;
  assign b_cols = cfg_i.flip_b ? cfg_i.dim_k : cfg_i.dim_n;
  assign row_bad = (row7 >= cfg_i.dim_m);

  assign t_last = (({1'b0, t_q} + 7'd1) == cfg_i.dim_k);
  assign j_last = (({1'b0, j_q} + 7'd1) == cfg_i.dim_n);

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.a_we = in_accept && (req_type_i == REQ_LOAD_A) && (row7 < a_rows) && (col7 < a_cols);
    cmd_o.b_we = in_accept && (req_type_i == REQ_LOAD_B) && (row7 < b_rows) && (col7 < b_cols);
    cmd_o.out_load_err = in_accept && (req_type_i == REQ_COMPUTE) && row_bad;
    unique case (state_q)
      ST_A_RD: begin
        cmd_o.a_re    = 1'b1;
        cmd_o.a_raddr = cfg_i.flip_a ? {t_q, row_q} : {row_q, t_q};
      end
      ST_A_WAIT: begin
        cmd_o.a_latch = 1'b1;
      end
      ST_B_ISSUE: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_first = pass_first_q;
        cmd_o.acc_re    = 1'b1;
        cmd_o.col       = j_q;
        cmd_o.b_raddr   = cfg_i.flip_b ? {j_q, t_q} : {t_q, j_q};
      end
      ST_OUT_RD: begin
        cmd_o.acc_re = 1'b1;
        cmd_o.col    = j_q;
      end
      ST_OUT_LOAD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.col      = j_q;
        cmd_o.out_zero = !any_pass_q;
        cmd_o.out_last = j_last;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      t_q          <= '0;
      j_q          <= '0;
      any_pass_q   <= 1'b0;
      pass_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && (req_type_i == REQ_COMPUTE)) begin
            if (row_bad) begin
              out_valid_q <= 1'b1;
              state_q     <= ST_ERR_SEND;
            end else begin
              row_q      <= row_index_i;
              t_q        <= '0;
              any_pass_q <= 1'b0;
              state_q    <= ST_A_RD;
            end
          end
        end
        ST_A_RD: begin
          state_q <= ST_A_WAIT;
        end
        ST_A_WAIT: begin
          if (stat_i.a_zero) begin
            if (t_last) begin
              state_q <= ST_DRAIN1;
            end else begin
              t_q     <= t_q + 1'b1;
              state_q <= ST_A_RD;
            end
          end else begin
            any_pass_q   <= 1'b1;
            pass_first_q <= !any_pass_q;
            j_q          <= '0;
            state_q      <= ST_B_ISSUE;
          end
        end
        ST_B_ISSUE: begin
          if (j_last) begin
            if (t_last) begin
              state_q <= ST_DRAIN1;
            end else begin
              t_q     <= t_q + 1'b1;
              state_q <= ST_A_RD;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_DRAIN1: begin
          state_q <= ST_DRAIN2;
        end
        ST_DRAIN2: begin
          j_q     <= '0;
          state_q <= ST_OUT_RD;
        end
        ST_OUT_RD: begin
          state_q <= ST_OUT_LOAD;
        end
        ST_OUT_LOAD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT_SEND;
        end
        ST_OUT_SEND: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (j_last) begin
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_OUT_RD;
            end
          end
        end
        ST_ERR_SEND: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is only offered from one of the two send states
  a_valid_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_OUT_SEND || state_q == ST_ERR_SEND))
    else $error("result valid outside a send state");

  // Requests are never taken while a result is pending
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("request taken while a result is pending");

  // Issued terms stay inside the output width
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_issue |-> ({1'b0, j_q} < cfg_i.dim_n))
    else $error("term issued beyond dim_n");

  // A bad row goes straight to the error result
  a_err_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (req_type_i == REQ_COMPUTE) && row_bad)
      |=> (state_q == ST_ERR_SEND && out_valid_q))
    else $error("bad row did not raise an error result");

endmodule
`default_nettype wire

@@ rtl/sparse_left_matrix_multiply.sv @@
// A compute request for output row i returns dim_n results, one per column in
// ascending order, each the exact Q21.16 sum over k of op(A)(i,k)*op(B)(k,j);
// a row at or beyond dim_m gives a single result with error set. Loads leave
// the block idle, and loads outside the configured shape are dropped silently.
// The block serves one request at a time. A compute steps through the inner
// index, each index costing an A store lookup (read and wait states); each
// non-zero A term of the row then feeds one B element per cycle through the
// single multiplier and B store read port. After two drain states, each result
// is read from the accumulator memory, loaded into the result register and
// handed out, held while the receiver stalls. There is no clearing pass after
// reset; the stores are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_left_matrix_multiply: zero-skipping sparse-by-dense row multiplier
// Configuration registers, dimension clamping, and the sequencer and
// datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module sparse_left_matrix_multiply import slmm_pkg::*; #(
  parameter int MAX_M     = 64,
  parameter int MAX_K     = 64,
  parameter int MAX_N     = 64,
  parameter int DATA_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [DIM_W-1:0]            cfg_wdata_i,
  // request channel
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic [IDX_W-1:0]            row_index_i,
  input  wire logic [IDX_W-1:0]            col_index_i,
  input  wire logic signed [DATA_BITS-1:0] element_value_i,
  // result channel
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [IDX_W-1:0]            out_col_o,
  output      logic signed [VAL_W-1:0]     out_value_o,
  output      logic                        last_o,
  output      logic                        error_o
);

  localparam logic [DIM_W-1:0] LIM_M = DIM_W'(MAX_M < SIDE ? MAX_M : SIDE);
  localparam logic [DIM_W-1:0] LIM_K = DIM_W'(MAX_K < SIDE ? MAX_K : SIDE);
  localparam logic [DIM_W-1:0] LIM_N = DIM_W'(MAX_N < SIDE ? MAX_N : SIDE);

  logic [DIM_W-1:0] dim_m_q, dim_k_q, dim_n_q;
  logic             flip_a_q, flip_b_q;
  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_m_q  <= 7'd64;
      dim_k_q  <= 7'd64;
      dim_n_q  <= 7'd64;
      flip_a_q <= 1'b0;
      flip_b_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIM_M:  dim_m_q  <= cfg_wdata_i;
        REG_DIM_K:  dim_k_q  <= cfg_wdata_i;
        REG_DIM_N:  dim_n_q  <= cfg_wdata_i;
        REG_FLIP_A: flip_a_q <= cfg_wdata_i[0];
        REG_FLIP_B: flip_b_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Clamped dimensions
  assign cfg.dim_m  = eff_dim(dim_m_q, LIM_M);
  assign cfg.dim_k  = eff_dim(dim_k_q, LIM_K);
  assign cfg.dim_n  = eff_dim(dim_n_q, LIM_N);
  assign cfg.flip_a = flip_a_q;
  assign cfg.flip_b = flip_b_q;

  slmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  slmm_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .last_o          (last_o),
    .error_o         (error_o)
  );

endmodule
`default_nettype wire

@@ tb/slmm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmm_checker: result predictor and scoreboard for the row multiplier
// Watches the register port and both channels. It keeps its own copy of the
// two element stores and the shape settings, and works out the result row of
// each compute request. Each accepted result is compared field by field with
// the oldest result still owed.
// ----------------------------------------------------------------------------
module slmm_checker import slmm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // register port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [DIM_W-1:0]        cfg_wdata_i,
  // request channel
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              req_type_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [15:0]      element_value_i,
  // result channel
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [IDX_W-1:0]        out_col_i,
  input  logic signed [VAL_W-1:0] out_value_i,
  input  logic                    last_i,
  input  logic                    error_i,
  // totals for the top level
  output int                      fail_count_o,
  output int                      outstanding_o,
  output int                      checked_o
);

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             error;
  } row_result_t;

  // Own copy of the stores, addressed row * SIDE + column
  logic signed [15:0] a_mem [SIDE*SIDE];
  logic signed [15:0] b_mem [SIDE*SIDE];

  // Register copies as written, clamped where used
  logic [DIM_W-1:0] raw_m, raw_k, raw_n;
  logic             flip_a, flip_b;

  row_result_t owed_results[$];
  row_result_t oldest;
  int          fails, checked, reported;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  // Apply one accepted request to the store copies, or queue its result row
  task automatic predict_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col, input logic signed [15:0] val);
    int          m, k, n, rows, cols;
    longint      sums [SIDE];
    longint      a_term, b_term;
    logic [63:0] wide;
    row_result_t res;
    m = clamp_dim(raw_m);
    k = clamp_dim(raw_k);
    n = clamp_dim(raw_n);
    case (kind)
      REQ_LOAD_A: begin
        rows = flip_a ? k : m;
        cols = flip_a ? m : k;
        if (row < rows && col < cols) a_mem[row*SIDE + col] = val;
      end
      REQ_LOAD_B: begin
        rows = flip_b ? n : k;
        cols = flip_b ? k : n;
        if (row < rows && col < cols) b_mem[row*SIDE + col] = val;
      end
      REQ_COMPUTE: begin
        if (row >= m) begin
          // row beyond the output: a single flagged result
          res.col   = '0;
          res.value = '0;
          res.last  = 1'b1;
          res.error = 1'b1;
          owed_results.push_back(res);
        end else begin
          for (int j = 0; j < SIDE; j++) sums[j] = 0;
          for (int t = 0; t < k; t++) begin
            a_term = flip_a ? a_mem[t*SIDE + row] : a_mem[row*SIDE + t];
            if (a_term != 0) begin
              for (int j = 0; j < n; j++) begin
                b_term = flip_b ? b_mem[j*SIDE + t] : b_mem[t*SIDE + j];
                sums[j] += a_term * b_term;
              end
            end
          end
          for (int j = 0; j < n; j++) begin
            wide      = sums[j];
            res.col   = j[IDX_W-1:0];
            res.value = wide[VAL_W-1:0];
            res.last  = (j == n - 1);
            res.error = 1'b0;
            owed_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_m    = 7'd64;
      raw_k    = 7'd64;
      raw_n    = 7'd64;
      flip_a   = 1'b0;
      flip_b   = 1'b0;
      fails    = 0;
      checked  = 0;
      reported = 0;
      owed_results.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DIM_M:  raw_m = cfg_wdata_i;
          REG_DIM_K:  raw_k = cfg_wdata_i;
          REG_DIM_N:  raw_n = cfg_wdata_i;
          REG_FLIP_A: flip_a = cfg_wdata_i[0];
          REG_FLIP_B: flip_b = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // results first, so a result is never matched against its own request
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          fails++;
          if (reported < 10)
            $display("[%0t] unexpected result: col %0d value %0d last %0b error %0b",
                     $time, out_col_i, out_value_i, last_i, error_i);
          reported++;
        end else begin
          oldest = owed_results.pop_front();
          checked++;
          if (out_col_i !== oldest.col || out_value_i !== oldest.value ||
              last_i !== oldest.last || error_i !== oldest.error) begin
            fails++;
            if (reported < 10)
              $display("[%0t] mismatch: expected col %0d value %0d last %0b error %0b,",
                       $time, oldest.col, $signed(oldest.value), oldest.last,
                       oldest.error, " got col %0d value %0d last %0b error %0b",
                       out_col_i, out_value_i, last_i, error_i);
            reported++;
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        predict_request(req_type_i, row_index_i, col_index_i, element_value_i);

      fail_count_o  <= fails;
      outstanding_o <= owed_results.size();
      checked_o     <= checked;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sparse-left row multiplier
// Loads operands and asks for output rows under a series of shapes and
// transpose settings, with random gaps and stalls on both channels. Before
// each compute it loads every operand entry the block will read. Checking
// is done by slmm_checker beside the block.
// ----------------------------------------------------------------------------
module testbench import slmm_pkg::*; ();

  localparam int          WATCHDOG_LIMIT = 8000;
  localparam int          HOLD_CYCLES    = 400;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [DIM_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              req_type_i;
  logic [IDX_W-1:0]        row_index_i;
  logic [IDX_W-1:0]        col_index_i;
  logic signed [15:0]      element_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [IDX_W-1:0]        out_col_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic                    last_o;
  logic                    error_o;

  int fail_count, outstanding, checked;

  // Which store entries hold data, so that no compute reads an empty one
  bit a_written [SIDE*SIDE];
  bit a_nonzero [SIDE*SIDE];
  bit b_written [SIDE*SIDE];

  // Shape in force, already clamped
  int cur_m, cur_k, cur_n;
  bit cur_ta, cur_tb;

  bit quiet;
  int hold_requests;
  int stored_loads, computes_sent, ignored_reqs, settings_run;
  int idle_count;

  sparse_left_matrix_multiply u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .last_o          (last_o),
    .error_o         (error_o)
  );

  slmm_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_col_i       (out_col_o),
    .out_value_i     (out_value_o),
    .last_i          (last_o),
    .error_i         (error_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int usable_dim(int raw);
    if (raw < 1) return 1;
    if (raw > SIDE) return SIDE;
    return raw;
  endfunction

  // Element values: plenty of zeros so that term skipping is exercised
  function automatic logic signed [15:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'sd0;
    if (r < 50) return 16'sh8000;
    if (r < 55) return 16'sh7fff;
    if (r < 60) return -16'sd1;
    return $urandom;
  endfunction

  // Offer one request, hold it until taken, then note what it stored
  task automatic send_req(input logic [1:0] kind, input int row, input int col,
                          input logic signed [15:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    row_index_i     <= row[IDX_W-1:0];
    col_index_i     <= col[IDX_W-1:0];
    element_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    case (kind)
      REQ_LOAD_A: begin
        if (row < (cur_ta ? cur_k : cur_m) && col < (cur_ta ? cur_m : cur_k)) begin
          a_written[row*SIDE + col] = 1'b1;
          a_nonzero[row*SIDE + col] = (val != 0);
          stored_loads++;
        end else ignored_reqs++;
      end
      REQ_LOAD_B: begin
        if (row < (cur_tb ? cur_n : cur_k) && col < (cur_tb ? cur_k : cur_n)) begin
          b_written[row*SIDE + col] = 1'b1;
          stored_loads++;
        end else ignored_reqs++;
      end
      REQ_COMPUTE: computes_sent++;
      default: ignored_reqs++;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Rewrite all registers once the block has gone quiet
  task automatic apply_setting(input int m, input int k, input int n, input bit ta,
                               input bit tb);
    in_valid_i <= 1'b0;
    wait_drained();
    // loads give no results and may still be in flight
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DIM_M;
    cfg_wdata_i <= m[DIM_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= REG_DIM_K;
    cfg_wdata_i <= k[DIM_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= REG_DIM_N;
    cfg_wdata_i <= n[DIM_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= REG_FLIP_A;
    cfg_wdata_i <= {6'd0, ta};
    @(posedge clk_i);
    cfg_idx_i   <= REG_FLIP_B;
    cfg_wdata_i <= {6'd0, tb};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_m  = usable_dim(m);
    cur_k  = usable_dim(k);
    cur_n  = usable_dim(n);
    cur_ta = ta;
    cur_tb = tb;
    settings_run++;
  endtask

  // Load every entry that a compute of this row will read and that is still empty
  task automatic fill_row_operands(input int row);
    int a_at, b_at;
    for (int t = 0; t < cur_k; t++) begin
      a_at = cur_ta ? t*SIDE + row : row*SIDE + t;
      if (!a_written[a_at]) send_req(REQ_LOAD_A, a_at / SIDE, a_at % SIDE, pick_element());
    end
    for (int t = 0; t < cur_k; t++) begin
      a_at = cur_ta ? t*SIDE + row : row*SIDE + t;
      if (a_nonzero[a_at]) begin
        for (int j = 0; j < cur_n; j++) begin
          b_at = cur_tb ? j*SIDE + t : t*SIDE + j;
          if (!b_written[b_at]) send_req(REQ_LOAD_B, b_at / SIDE, b_at % SIDE, pick_element());
        end
      end
    end
  endtask

  // A mix of well-formed computes, loads in and out of the shape, rows past the end and junk codes
  task automatic random_phase(input int budget, input bit with_hold);
    int         start, done_items, pick, row, col, rows, cols;
    bit         held;
    logic [1:0] kind;
    start = stored_loads + computes_sent;
    held  = 1'b0;
    done_items = 0;
    while (done_items < budget) begin
      if (with_hold && !held && done_items >= 8) begin
        hold_requests++;
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        row = $urandom_range(0, cur_m - 1);
        fill_row_operands(row);
        send_req(REQ_COMPUTE, row, $urandom, $urandom);
      end else if (pick < 55) begin
        if (cur_m < SIDE)
          send_req(REQ_COMPUTE, $urandom_range(cur_m, SIDE - 1), $urandom, $urandom);
      end else if (pick < 92) begin
        kind = (pick < 75) ? REQ_LOAD_A : REQ_LOAD_B;
        if (kind == REQ_LOAD_A) begin
          rows = cur_ta ? cur_k : cur_m;
          cols = cur_ta ? cur_m : cur_k;
        end else begin
          rows = cur_tb ? cur_n : cur_k;
          cols = cur_tb ? cur_k : cur_n;
        end
        if ($urandom_range(0, 2) != 0) begin
          row = $urandom_range(0, rows - 1);
          col = $urandom_range(0, cols - 1);
        end else begin
          row = $urandom_range(0, SIDE - 1);
          col = $urandom_range(0, SIDE - 1);
        end
        send_req(kind, row, col, pick_element());
      end else begin
        send_req(REQ_UNUSED, $urandom, $urandom, $urandom);
      end
      done_items = stored_loads + computes_sent - start;
    end
  endtask

  // Result side: random stall bursts, long hold-offs on request, none at the end
  initial begin
    int stall_left, run_left, holds_served;
    stall_left   = 0;
    run_left     = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (quiet || run_left > 0) begin
        out_stall_i <= 1'b0;
        if (run_left > 0) run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_stall_i <= 1'b0;
        run_left = $urandom_range(0, 40);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d results still owed",
               $time, idle_count, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_LOAD_A;
    row_index_i     = '0;
    col_index_i     = '0;
    element_value_i = '0;
    idle_count      = 0;
    cur_m = 64; cur_k = 64; cur_n = 64;
    cur_ta = 1'b0; cur_tb = 1'b0;
    quiet = 1'b0;
    hold_requests = 0;
    stored_loads = 0; computes_sent = 0; ignored_reqs = 0; settings_run = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme operands, a zero row, rows past the end, dropped loads
    apply_setting(48, 2, 3, 1'b0, 1'b0);
    send_req(REQ_LOAD_A, 47, 0, 16'sh8000);
    send_req(REQ_LOAD_A, 47, 1, 16'sh7fff);
    send_req(REQ_LOAD_B, 0, 0, 16'sh8000);
    send_req(REQ_LOAD_B, 0, 1, 16'sh7fff);
    send_req(REQ_LOAD_B, 0, 2, 16'sd1);
    send_req(REQ_LOAD_B, 1, 0, 16'sh8000);
    send_req(REQ_LOAD_B, 1, 1, 16'sd0);
    send_req(REQ_LOAD_B, 1, 2, -16'sd1);
    send_req(REQ_COMPUTE, 47, 63, -16'sd1);
    send_req(REQ_LOAD_A, 0, 0, 16'sd0);
    send_req(REQ_LOAD_A, 0, 1, 16'sd0);
    send_req(REQ_COMPUTE, 0, 0, 16'sd0);
    send_req(REQ_COMPUTE, 48, 0, 16'sd0);
    send_req(REQ_COMPUTE, 63, 63, 16'sh7fff);
    send_req(REQ_LOAD_A, 63, 63, 16'sh5555);
    send_req(REQ_LOAD_B, 63, 63, 16'sh2aaa);
    send_req(REQ_UNUSED, 63, 63, -16'sd1);
    send_req(REQ_LOAD_A, 47, 0, 16'sd1);
    send_req(REQ_COMPUTE, 47, 0, 16'sd0);

    // Random: zero and over-range dimensions are clamped by the block
    apply_setting(127, 0, 127, 1'b1, 1'b0);
    random_phase(50, 1'b1);
    apply_setting(1, 127, 1, 1'b0, 1'b1);
    random_phase(50, 1'b0);
    apply_setting(5, 6, 7, 1'b1, 1'b1);
    random_phase(50, 1'b0);
    apply_setting(8, 3, 4, 1'b0, 1'b0);
    random_phase(50, 1'b0);
    apply_setting(3, 8, 5, 1'b0, 1'b1);
    random_phase(50, 1'b0);
    apply_setting(6, 4, 6, 1'b1, 1'b0);
    random_phase(50, 1'b0);
    apply_setting(0, 0, 0, 1'b1, 1'b1);
    random_phase(50, 1'b0);
    quiet = 1'b1;
    apply_setting(7, 5, 6, 1'b0, 1'b0);
    random_phase(50, 1'b0);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d stored loads, %0d compute requests",
             stored_loads, computes_sent,
             " and %0d dropped or ignored requests under %0d shape settings",
             ignored_reqs, settings_run);
    $display("%0d results compared, %0d failures", checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
